// File: rtl/core/tpl_pkg.sv
package tpl_pkg;

  localparam int MAX_COLUMNS_LIMIT = 136;
  localparam int TAB_STOP          = 8;

  localparam int COL_W     = 8;
  localparam int LINE_W    = 8;
  localparam int BYTE_W    = 8;
  localparam int EV_W      = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;
  localparam int SUM_W     = 9;
  localparam int TPH_W     = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int ADD_W     = $clog2(TAB_STOP + 1);

  localparam logic [CFG_W-1:0] COLS_RESET  = 8'd80;
  localparam logic [CFG_W-1:0] LINES_RESET = 8'd60;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADV  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOJ  = 2'd2;

  localparam logic [EV_W-1:0] EV_GLYPH = 2'd0;
  localparam logic [EV_W-1:0] EV_LINE  = 2'd1;
  localparam logic [EV_W-1:0] EV_PAGE  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF   = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL  = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CSI  = 8'h9B;
  localparam logic [BYTE_W-1:0] CH_FILL = 8'hFF;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_TAB    = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_PLACE  = 7'b0010000,
    ST_LINE   = 7'b0100000,
    ST_PAGE   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    LM_BREAK = 2'd0,
    LM_FF    = 2'd1,
    LM_EOJ   = 2'd2
  } line_mode_t;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] glyph;
    logic              ff;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] a;
    logic [ADD_W-1:0] addend;
    logic [SUM_W-1:0] lim_a;
    logic [COL_W-1:0] lim_b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ge_a;
    logic             ge_b;
  } alu_rsp_t;

endpackage

// File: rtl/core/tpl_alu.sv
module tpl_alu
  import tpl_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [SUM_W-1:0] sum;

  assign sum      = SUM_W'(req.a) + SUM_W'(req.addend);
  assign rsp.sum  = sum;
  assign rsp.ge_a = (sum >= req.lim_a);
  assign rsp.ge_b = (sum >= SUM_W'(req.lim_b));

endmodule

// File: rtl/core/tpl_outreg.sv
module tpl_outreg
  import tpl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t din,
  input  logic    out_stall,
  output logic    free,
  output logic    out_valid,
  output result_t dout
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);
  assign out_valid = valid_r;
  assign dout      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

// File: rtl/core/text_page_line_layout_unit.sv
// Lays printer input out into lines and pages. Each accepted transaction passes through
// the input register and a decoding step, then, for a tab only, a stop-and-clamp step
// and a check step, and then emits its results one at a time: a tab gives at most
// eight spaces, a line close and a page close. One shared add-and-compare unit, driven
// by the sequencer, settles every column, tab stop and line count, and it limits the
// block to one result per cycle. in_stall is high from acceptance until the last
// result has entered the output register; out_stall holds the sequencer only while
// that register is full. The user must write the configuration registers only while
// the block is idle; the block itself does not enforce this.
module text_page_line_layout_unit
  import tpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [BYTE_W-1:0]    in_byte_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [EV_W-1:0]      out_event_res,
  output logic [LINE_W-1:0]    out_line_index,
  output logic [COL_W-1:0]     out_column,
  output logic [BYTE_W-1:0]    out_glyph,
  output logic                 out_form_feed_close,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t            state_r,  state_nxt;
  logic [COL_W-1:0]  col_r,    col_nxt;
  logic [LINE_W-1:0] line_r,   line_nxt;
  logic              acr_r,    acr_nxt;
  logic [TPH_W-1:0]  tabph_r,  tabph_nxt;
  logic [SUM_W-1:0]  stop_r,   stop_nxt;
  logic              tab_r,    tab_nxt;
  line_mode_t        lm_r,     lm_nxt;
  logic              pg_ff_r,  pg_ff_nxt;
  logic [KIND_W-1:0] kind_r,   kind_nxt;
  logic [BYTE_W-1:0] byte_r,   byte_nxt;
  logic [CFG_W-1:0]  cols_cfg_r;
  logic [CFG_W-1:0]  lines_cfg_r;

  logic [COL_W-1:0]  eff_cols;
  logic [LINE_W-1:0] eff_lines;
  logic [TPH_W-1:0]  tabph_inc;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  result_t  res;
  result_t  res_q;
  logic     emit;
  logic     out_free;

  tpl_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  tpl_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .din       (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .dout      (res_q)
  );

  assign out_event_res       = res_q.ev;
  assign out_line_index      = res_q.line;
  assign out_column          = res_q.col;
  assign out_glyph           = res_q.glyph;
  assign out_form_feed_close = res_q.ff;
  assign out_last            = res_q.last;

  assign in_stall = (state_r != ST_IDLE);

  assign eff_cols  = (cols_cfg_r == '0) ? COL_W'(1) :
                     (cols_cfg_r > COL_W'(MAX_COLUMNS_LIMIT)) ? COL_W'(MAX_COLUMNS_LIMIT) :
                     cols_cfg_r;
  assign eff_lines = (lines_cfg_r == '0) ? LINE_W'(1) : lines_cfg_r;
  assign tabph_inc = (tabph_r == TPH_W'(TAB_STOP - 1)) ? '0 : tabph_r + TPH_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r  <= COLS_RESET;
      lines_cfg_r <= LINES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS:  cols_cfg_r  <= cfg_data;
        CFG_LINES: lines_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    line_nxt  = line_r;
    acr_nxt   = acr_r;
    tabph_nxt = tabph_r;
    stop_nxt  = stop_r;
    tab_nxt   = tab_r;
    lm_nxt    = lm_r;
    pg_ff_nxt = pg_ff_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    alu_req   = '0;
    res       = '0;
    emit      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          byte_nxt  = in_byte_in;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (kind_r)
          KIND_DATA: begin
            if (byte_r == CH_ESC || byte_r == CH_CSI || byte_r == CH_FILL) begin
              state_nxt = ST_IDLE;
            end else if (byte_r == CH_CR) begin
              acr_nxt   = 1'b1;
              lm_nxt    = LM_BREAK;
              state_nxt = ST_LINE;
            end else if (byte_r == CH_LF) begin
              if (acr_r) begin
                acr_nxt = 1'b0;
              end else begin
                lm_nxt    = LM_BREAK;
                state_nxt = ST_LINE;
              end
            end else begin
              acr_nxt = 1'b0;
              if (byte_r == CH_FF) begin
                if (col_r != '0) begin
                  lm_nxt    = LM_FF;
                  state_nxt = ST_LINE;
                end else begin
                  pg_ff_nxt = 1'b1;
                  state_nxt = ST_PAGE;
                end
              end else if (byte_r == CH_TAB) begin
                tab_nxt   = 1'b1;
                state_nxt = ST_TAB;
              end else if (byte_r >= CH_SP && byte_r != CH_DEL) begin
                tab_nxt   = 1'b0;
                state_nxt = ST_PLACE;
              end
            end
          end
          KIND_ADV: begin
            acr_nxt   = 1'b0;
            lm_nxt    = LM_BREAK;
            state_nxt = ST_LINE;
          end
          KIND_EOJ: begin
            acr_nxt = 1'b0;
            if (col_r != '0) begin
              lm_nxt    = LM_EOJ;
              state_nxt = ST_LINE;
            end else if (line_r != '0) begin
              pg_ff_nxt = 1'b0;
              state_nxt = ST_PAGE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_TAB: begin
        alu_req.a      = col_r;
        alu_req.addend = ADD_W'(TAB_STOP) - ADD_W'(tabph_r);
        alu_req.lim_b  = eff_cols;
        stop_nxt       = alu_rsp.ge_b ? SUM_W'(eff_cols) : alu_rsp.sum;
        state_nxt      = ST_CHECK;
      end

      ST_CHECK: begin
        alu_req.a     = col_r;
        alu_req.lim_a = stop_r;
        alu_req.lim_b = eff_cols;
        if (!alu_rsp.ge_a) begin
          state_nxt = ST_PLACE;
        end else if (alu_rsp.ge_b) begin
          lm_nxt    = LM_BREAK;
          state_nxt = ST_LINE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_PLACE: begin
        alu_req.a      = col_r;
        alu_req.addend = ADD_W'(1);
        alu_req.lim_a  = stop_r;
        alu_req.lim_b  = eff_cols;
        res.ev    = EV_GLYPH;
        res.line  = line_r;
        res.col   = col_r;
        res.glyph = tab_r ? CH_SP : byte_r;
        res.last  = !(tab_r && !alu_rsp.ge_a) && !alu_rsp.ge_b;
        if (out_free) begin
          emit      = 1'b1;
          col_nxt   = alu_rsp.sum[COL_W-1:0];
          tabph_nxt = tabph_inc;
          if (tab_r && !alu_rsp.ge_a) begin
            state_nxt = ST_PLACE;
          end else if (alu_rsp.ge_b) begin
            lm_nxt    = LM_BREAK;
            state_nxt = ST_LINE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_LINE: begin
        alu_req.a      = line_r;
        alu_req.addend = ADD_W'(1);
        alu_req.lim_b  = eff_lines;
        res.ev   = EV_LINE;
        res.line = line_r;
        res.col  = col_r;
        res.last = (lm_r == LM_BREAK) && !alu_rsp.ge_b;
        if (out_free) begin
          emit = 1'b1;
          case (lm_r)
            LM_BREAK: begin
              col_nxt   = '0;
              tabph_nxt = '0;
              line_nxt  = alu_rsp.ge_b ? '0 : alu_rsp.sum[LINE_W-1:0];
              pg_ff_nxt = 1'b0;
              state_nxt = alu_rsp.ge_b ? ST_PAGE : ST_IDLE;
            end
            LM_FF: begin
              pg_ff_nxt = 1'b1;
              state_nxt = ST_PAGE;
            end
            LM_EOJ: begin
              pg_ff_nxt = 1'b0;
              state_nxt = ST_PAGE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_PAGE: begin
        res.ev   = EV_PAGE;
        res.ff   = pg_ff_r;
        res.last = 1'b1;
        if (out_free) begin
          emit      = 1'b1;
          col_nxt   = '0;
          line_nxt  = '0;
          tabph_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      line_r  <= '0;
      acr_r   <= 1'b0;
      tabph_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      acr_r   <= acr_nxt;
      tabph_r <= tabph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stop_r  <= stop_nxt;
    tab_r   <= tab_nxt;
    lm_r    <= lm_nxt;
    pg_ff_r <= pg_ff_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DECODE))
    else $error("accepted transaction not decoded");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(MAX_COLUMNS_LIMIT))
    else $error("column past limit");

  a_page_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_PAGE) |-> (out_last && out_column == '0))
    else $error("page close not final");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded over a held one");

endmodule
